// ===== hw/rtl/bab_pkg.sv =====
// Shared types, constants and a helper function of the block allocation bitmap.
package bab_pkg;

   localparam int MAP_BYTES_DEFAULT = 512;
   localparam int BLOCK_W = 12;
   localparam int BYTE_IX_W = 9;
   localparam int BIT_IX_W = 3;
   localparam int COUNT_W = 10;
   localparam int FIND_BYTES = 512;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] FULL_BYTE = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd512;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAP_BYTES = 2'd0;

   typedef enum logic [1:0] {
      MODE_TEST    = 2'd0,
      MODE_FIND    = 2'd1,
      MODE_ASSIGN  = 2'd2,
      MODE_RELEASE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NONE_FREE = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW,
      ST_SCAN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [BLOCK_W-1:0] block_number;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               block_free;
      logic [BLOCK_W-1:0] found_block;
   } rsp_type;

   function automatic logic [BIT_IX_W-1:0] first_zero(input logic [7:0] map_byte);
      logic [BIT_IX_W-1:0] pos;
      pos = '0;
      for (int i = 7; i >= 0; i--) begin
         if (!map_byte[i]) begin
            pos = BIT_IX_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ===== hw/rtl/bab_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module bab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/block_allocation_bitmap.sv =====
// Block allocation bitmap: one bit per storage block held in a byte-wide RAM.
//
// Each request word tests, finds, assigns or releases a block and yields one
// response word. Test, assign and release read the map byte from the RAM
// and then check it or write the modified byte back through the same RAM.
// A find reads one byte after another, starting at byte zero and stopping at
// the first byte that is not full or at the last byte in use (at most 512).
// A request with a block number out of range, or a find while no byte is in
// use, is answered from the hold state. After reset the map is cleared one
// byte per cycle over the smaller of MAP_BYTES and 512 bytes; no request word
// is taken during that pass, although register writes are. The response
// register lets a new request start while the previous response word waits
// to be taken.
module block_allocation_bitmap #(
   parameter int MAP_BYTES = bab_pkg::MAP_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bab_pkg::req_type                    req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bab_pkg::rsp_type                    rsp_word,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bab_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bab_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bab_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   import bab_pkg::*;

   localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CLEAR_BYTES = (MAP_BYTES < FIND_BYTES) ? MAP_BYTES : FIND_BYTES;

   state_type                 state_ff, state_in;
   logic [BYTE_IX_W-1:0]      clr_ff, clr_in;
   logic [BYTE_IX_W-1:0]      scan_ff, scan_in;
   logic [1:0]                mode_ff, mode_in;
   logic [BLOCK_W-1:0]        blk_ff, blk_in;
   rsp_type                   hold_ff, hold_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]        cfg_ff, cfg_in;

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [7:0]                wr_data;
   logic [ADDR_W-1:0]         rd_addr;
   logic [7:0]                rd_data;

   logic [COUNT_W-1:0]        live_bytes;
   logic [COUNT_W-1:0]        scan_limit;
   logic                      in_range;
   logic                      slot_free;
   logic [7:0]                bit_mask;
   rsp_type                   res;
   logic                      res_ready;
   logic                      cfg_write;

   bab_ram #(
      .WIDTH (8),
      .DEPTH (MAP_BYTES)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_MAP_BYTES) ?
                       {{(CSR_DATA_W-COUNT_W){1'b0}}, cfg_ff} : '0;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write && csr_paddr == ADDR_MAP_BYTES) begin
         cfg_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      if ({{(32-COUNT_W){1'b0}}, cfg_ff} > 32'(MAP_BYTES)) begin
         live_bytes = COUNT_W'(MAP_BYTES);
      end else begin
         live_bytes = cfg_ff;
      end
      if (live_bytes > COUNT_W'(FIND_BYTES)) begin
         scan_limit = COUNT_W'(FIND_BYTES);
      end else begin
         scan_limit = live_bytes;
      end
   end

   assign in_range  = {1'b0, req_word.block_number[BLOCK_W-1:BIT_IX_W]} < live_bytes;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign bit_mask  = 8'd1 << blk_ff[BIT_IX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      mode_in      = mode_ff;
      blk_in       = blk_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(blk_ff[BLOCK_W-1:BIT_IX_W]);
      wr_data      = rd_data;
      rd_addr      = ADDR_W'(req_word.block_number[BLOCK_W-1:BIT_IX_W]);
      res          = '0;
      res_ready    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(clr_ff);
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == BYTE_IX_W'(CLEAR_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in = req_word.mode;
               blk_in  = req_word.block_number;
               if (req_word.mode == MODE_FIND) begin
                  rd_addr = '0;
                  scan_in = '0;
                  if (scan_limit == '0) begin
                     hold_in  = '{status: STATUS_NONE_FREE, block_free: 1'b0, found_block: '0};
                     state_in = ST_HOLD;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else if (in_range) begin
                  state_in = ST_RMW;
               end else begin
                  hold_in  = '{status: STATUS_RANGE, block_free: 1'b0, found_block: '0};
                  state_in = ST_HOLD;
               end
            end
         end
         ST_RMW: begin
            res.status = STATUS_OK;
            res_ready  = 1'b1;
            unique case (mode_ff)
               MODE_TEST: begin
                  res.block_free = ~|(rd_data & bit_mask);
               end
               MODE_ASSIGN: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data | bit_mask;
               end
               MODE_RELEASE: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data & ~bit_mask;
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
         ST_SCAN: begin
            if (rd_data != FULL_BYTE) begin
               res.status      = STATUS_OK;
               res.found_block = {scan_ff, first_zero(rd_data)};
               res_ready       = 1'b1;
            end else if ({1'b0, scan_ff} + 10'd1 >= scan_limit) begin
               res.status = STATUS_NONE_FREE;
               res_ready  = 1'b1;
            end else begin
               scan_in = scan_ff + 1'b1;
               rd_addr = ADDR_W'(scan_ff + 1'b1);
            end
         end
         ST_HOLD: begin
            res       = hold_ff;
            res_ready = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (res_ready) begin
         if (slot_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            hold_in  = res;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      scan_ff <= scan_in;
      mode_ff <= mode_in;
      blk_ff  <= blk_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
